>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file. Each macro expects clk and
// rst_n in scope. Assertions are off while reset is held.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/nfcm_pkg.sv
// ----------------------------------------------------------------------------
// nfcm_pkg
// Types, constants and colormap coefficient functions of the false color
// mapper.
// ----------------------------------------------------------------------------
package nfcm_pkg;

  localparam int SAMPLE_BITS   = 32;
  localparam int FRACTION_BITS = 16;

  // signed width that holds differences of two samples and their negation
  localparam int EXT_W     = SAMPLE_BITS + 2;
  // normalized value, unsigned Q1.FRACTION_BITS
  localparam int NORM_W    = FRACTION_BITS + 1;
  localparam int SEG_CMP_W = NORM_W + 2;
  localparam int CNT_W     = $clog2(FRACTION_BITS + 1);

  // shared color datapath
  localparam int MUL_W       = FRACTION_BITS + 3;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int KMUL_W      = 14;
  localparam int SCL_W       = PROD_W + KMUL_W;
  localparam int Y_W         = 18;
  localparam int RECIP_W     = 27;
  localparam int RECIP_SHIFT = 26;
  localparam int QF_W        = Y_W + RECIP_W;
  localparam int Q_W         = QF_W - RECIP_SHIFT;
  localparam int C1_W        = 11;
  localparam int C0_W        = 9;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;
  localparam int CMAP_W     = 3;

  localparam logic [NORM_W-1:0]        NORM_ONE   = NORM_W'(1) << FRACTION_BITS;
  localparam logic signed [KMUL_W-1:0] K_LIN      = 14'sd255;
  localparam logic signed [KMUL_W-1:0] K_QUAD     = 14'sd5763;
  localparam logic [Y_W-1:0]           Y_QUAD_OFS = 18'd306;
  localparam logic [Q_W-1:0]           CHAN_MAX   = Q_W'(255);

  typedef enum logic [1:0] {
    OP_FIRST = 2'd0,
    OP_SCAN  = 2'd1,
    OP_MAP   = 2'd2
  } op_t;

  typedef enum logic [CMAP_W-1:0] {
    CM_GRAY     = 3'd0,
    CM_JET      = 3'd1,
    CM_HOT      = 3'd2,
    CM_VIRIDIS  = 3'd3,
    CM_COOLWARM = 3'd4
  } cmap_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLORMAP  = 2'd0,
    CFG_SYMMETRIC = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEG_0 = 2'd0,
    SEG_1 = 2'd1,
    SEG_2 = 2'd2,
    SEG_3 = 2'd3
  } seg_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  typedef enum logic [1:0] {
    DS_1    = 2'd0,
    DS_80   = 2'd1,
    DS_100  = 2'd2,
    DS_1000 = 2'd3
  } dsel_t;

  typedef struct packed {
    logic [1:0]                    operation;
    logic signed [SAMPLE_BITS-1:0] sample_value;
  } nfcm_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } nfcm_out_t;

  // channel = floor(255 * (c1*n + c0*ONE) / (D*ONE)), or the viridis blue
  // quadratic when quad is set
  typedef struct packed {
    logic signed [C1_W-1:0] c1;
    logic signed [C0_W-1:0] c0;
    logic                   quad;
    dsel_t                  dsel;
  } coef_t;

  typedef struct packed {
    logic             start;
    logic [EXT_W-1:0] dividend;
    logic [EXT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic [FRACTION_BITS-1:0] quot;
  } div_sts_t;

  typedef struct packed {
    logic              start;
    logic [NORM_W-1:0] n;
    logic [CMAP_W-1:0] cmap;
  } clr_req_t;

  typedef struct packed {
    logic      done;
    nfcm_out_t rgb;
  } clr_sts_t;

  function automatic coef_t coef_of(input logic [CMAP_W-1:0] cmap, input seg_t seg,
                                    input chan_t ch);
    coef_t c;
    c.c1   = '0;
    c.c0   = '0;
    c.quad = 1'b0;
    c.dsel = DS_1;
    unique case (cmap)
      CM_JET: begin
        unique case (seg)
          SEG_0: begin
            if (ch == CH_GREEN) c.c1 = 11'sd4;
            else if (ch == CH_BLUE) c.c0 = 9'sd1;
          end
          SEG_1: begin
            if (ch == CH_GREEN) c.c0 = 9'sd1;
            else if (ch == CH_BLUE) begin
              c.c1 = -11'sd4;
              c.c0 = 9'sd2;
            end
          end
          SEG_2: begin
            if (ch == CH_RED) begin
              c.c1 = 11'sd4;
              c.c0 = -9'sd2;
            end else if (ch == CH_GREEN) c.c0 = 9'sd1;
          end
          default: begin
            if (ch == CH_RED) c.c0 = 9'sd1;
            else if (ch == CH_GREEN) begin
              c.c1 = -11'sd4;
              c.c0 = 9'sd4;
            end
          end
        endcase
      end
      CM_HOT: begin
        unique case (seg)
          SEG_0: begin
            if (ch == CH_RED) c.c1 = 11'sd3;
          end
          SEG_1: begin
            if (ch == CH_RED) c.c0 = 9'sd1;
            else if (ch == CH_GREEN) begin
              c.c1 = 11'sd3;
              c.c0 = -9'sd1;
            end
          end
          default: begin
            if (ch == CH_BLUE) begin
              c.c1 = 11'sd3;
              c.c0 = -9'sd2;
            end else c.c0 = 9'sd1;
          end
        endcase
      end
      CM_VIRIDIS: begin
        c.dsel = DS_1000;
        if (ch == CH_RED) begin
          c.c1 = 11'sd267;
          c.c0 = 9'sd4;
        end else if (ch == CH_GREEN) begin
          c.c1 = 11'sd865;
          c.c0 = 9'sd4;
        end else begin
          c.quad = 1'b1;
          c.dsel = DS_80;
        end
      end
      CM_COOLWARM: begin
        c.dsel = DS_100;
        // lower half in terms of t = 2n, upper half in terms of t = 2n - 1
        if (seg == SEG_0) begin
          if (ch == CH_RED) begin
            c.c1 = 11'sd154;
            c.c0 = 9'sd23;
          end else if (ch == CH_GREEN) begin
            c.c1 = 11'sd142;
            c.c0 = 9'sd29;
          end else begin
            c.c1 = 11'sd50;
            c.c0 = 9'sd75;
          end
        end else begin
          if (ch == CH_RED) begin
            c.c1 = -11'sd26;
            c.c0 = 9'sd113;
          end else if (ch == CH_GREEN) begin
            c.c1 = -11'sd138;
            c.c0 = 9'sd169;
          end else begin
            c.c1 = -11'sd168;
            c.c0 = 9'sd184;
          end
        end
      end
      default: begin
        c.c1 = 11'sd1;
      end
    endcase
    return c;
  endfunction

  // ceil(2^RECIP_SHIFT / D), exact floor for every quotient input below 2^Y_W
  function automatic logic [RECIP_W-1:0] recip_of(input dsel_t dsel);
    logic [RECIP_W-1:0] m;
    unique case (dsel)
      DS_80:   m = 27'd838861;
      DS_100:  m = 27'd671089;
      DS_1000: m = 27'd67109;
      default: m = RECIP_W'(1) << RECIP_SHIFT;
    endcase
    return m;
  endfunction

endpackage

>>> sv/nfcm_div.sv
// ----------------------------------------------------------------------------
// nfcm_div
// Restoring radix-2 divider, one fraction bit of the normalized value per
// cycle. Dividend must be below the divisor.
// ----------------------------------------------------------------------------
module nfcm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  nfcm_pkg::div_req_t req,
  output nfcm_pkg::div_sts_t sts
);
  import nfcm_pkg::*;

  logic [EXT_W-1:0]         rem_r;
  logic [EXT_W-1:0]         dvs_r;
  logic [FRACTION_BITS-1:0] quo_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     busy_r;
  logic                     done_r;
  logic [EXT_W-1:0]         rem_sh;
  logic                     fits;
  logic [EXT_W-1:0]         rem_nxt;

  assign rem_sh  = {rem_r[EXT_W-2:0], 1'b0};
  assign fits    = (rem_sh >= dvs_r);
  assign rem_nxt = fits ? (rem_sh - dvs_r) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(FRACTION_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend;
      dvs_r <= req.divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[FRACTION_BITS-2:0], fits};
    end
  end

  assign sts.done = done_r;
  assign sts.quot = quo_r;

endmodule

>>> sv/nfcm_color.sv
// ----------------------------------------------------------------------------
// nfcm_color
// Colormap evaluation. One multiply, scale and reciprocal-divide path is
// stepped through the three channels in turn.
// ----------------------------------------------------------------------------
module nfcm_color (
  input  logic               clk,
  input  logic               rst_n,
  input  nfcm_pkg::clr_req_t req,
  output nfcm_pkg::clr_sts_t sts
);
  import nfcm_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE  = 4'b0001,
    C_TERM  = 4'b0010,
    C_SCALE = 4'b0100,
    C_QUOT  = 4'b1000
  } cstate_t;

  cstate_t                  state_r, state_nxt;
  chan_t                    ch_r;
  logic                     done_r;
  logic [NORM_W-1:0]        n_r;
  logic [CMAP_W-1:0]        cmap_r;
  seg_t                     seg_r;
  coef_t                    coef_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [Y_W-1:0]           y_r;
  logic [7:0]               red_r, green_r, blue_r;

  // segment of the piecewise maps
  logic [SEG_CMP_W-1:0] n_e, n2, n3, n4, one_e, one2, one3;
  seg_t                 seg_in;

  assign n_e   = SEG_CMP_W'(req.n);
  assign n2    = n_e << 1;
  assign n3    = n_e + n2;
  assign n4    = n_e << 2;
  assign one_e = SEG_CMP_W'(NORM_ONE);
  assign one2  = one_e << 1;
  assign one3  = one_e + one2;

  always_comb begin
    seg_in = SEG_0;
    unique case (req.cmap)
      CM_JET: begin
        if (n4 < one_e) seg_in = SEG_0;
        else if (n2 < one_e) seg_in = SEG_1;
        else if (n4 < one3) seg_in = SEG_2;
        else seg_in = SEG_3;
      end
      CM_HOT: begin
        if (n3 < one_e) seg_in = SEG_0;
        else if (n3 < one2) seg_in = SEG_1;
        else seg_in = SEG_2;
      end
      CM_COOLWARM: begin
        if (n2 < one_e) seg_in = SEG_0;
        else seg_in = SEG_1;
      end
      default: seg_in = SEG_0;
    endcase
  end

  // term step: c1*n + c0*ONE, or n*(3*ONE - 2*n) for viridis blue
  coef_t                    coef;
  logic [MUL_W-1:0]         n_m;
  logic [MUL_W-1:0]         quad_b;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] ofs;
  logic signed [PROD_W-1:0] prod_nxt;

  assign coef   = coef_of(cmap_r, seg_r, ch_r);
  assign n_m    = MUL_W'(n_r);
  assign quad_b = ((MUL_W'(NORM_ONE) << 1) + MUL_W'(NORM_ONE)) - (n_m << 1);

  always_comb begin
    if (coef.quad) begin
      mul_a = $signed(n_m);
      mul_b = $signed(quad_b);
      ofs   = '0;
    end else begin
      mul_a = MUL_W'(coef.c1);
      mul_b = $signed(n_m);
      ofs   = PROD_W'(coef.c0) <<< FRACTION_BITS;
    end
    prod_nxt = PROD_W'(mul_a * mul_b) + ofs;
  end

  // scale step: times 255 over ONE, or the viridis blue polynomial over ONE^2
  logic signed [SCL_W-1:0] scl, sh_lin, sh_quad;
  logic [Y_W-1:0]          y_nxt;

  assign scl     = SCL_W'(prod_r) * SCL_W'(coef_r.quad ? K_QUAD : K_LIN);
  assign sh_lin  = scl >>> FRACTION_BITS;
  assign sh_quad = scl >>> (2 * FRACTION_BITS);
  assign y_nxt   = coef_r.quad ? (sh_quad[Y_W-1:0] + Y_QUAD_OFS) : sh_lin[Y_W-1:0];

  // divide by the map's denominator through a reciprocal, then clamp
  logic [QF_W-1:0] qf;
  logic [Q_W-1:0]  q;
  logic [7:0]      chan_val;

  assign qf       = QF_W'(y_r) * QF_W'(recip_of(coef_r.dsel));
  assign q        = qf[QF_W-1:RECIP_SHIFT];
  assign chan_val = (q > CHAN_MAX) ? 8'hff : q[7:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE:  if (req.start) state_nxt = C_TERM;
      C_TERM:  state_nxt = C_SCALE;
      C_SCALE: state_nxt = C_QUOT;
      C_QUOT:  state_nxt = (ch_r == CH_BLUE) ? C_IDLE : C_TERM;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      ch_r    <= CH_RED;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= 1'b0;
      if (state_r == C_IDLE && req.start) begin
        ch_r <= CH_RED;
      end else if (state_r == C_QUOT) begin
        unique case (ch_r)
          CH_RED:   ch_r <= CH_GREEN;
          CH_GREEN: ch_r <= CH_BLUE;
          default: begin
            ch_r   <= CH_RED;
            done_r <= 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == C_IDLE && req.start) begin
      n_r    <= req.n;
      cmap_r <= req.cmap;
      seg_r  <= seg_in;
    end
    if (state_r == C_TERM) begin
      coef_r <= coef;
      prod_r <= prod_nxt;
    end
    if (state_r == C_SCALE) y_r <= y_nxt;
    if (state_r == C_QUOT) begin
      unique case (ch_r)
        CH_RED:   red_r   <= chan_val;
        CH_GREEN: green_r <= chan_val;
        default:  blue_r  <= chan_val;
      endcase
    end
  end

  assign sts.done      = done_r;
  assign sts.rgb.red   = red_r;
  assign sts.rgb.green = green_r;
  assign sts.rgb.blue  = blue_r;

endmodule

>>> sv/normalized_false_color_mapper_core.sv
// ----------------------------------------------------------------------------
// normalized_false_color_mapper_core
// Min/max normalized false color mapper. Scan beats (first scan, scan) update
// the running minimum and maximum and are taken one per cycle, with no result,
// while no map beat is in work or waiting for the output register. A map beat
// normalizes its sample to Q1.16 against that scale (symmetric about zero if
// selected) and returns one RGB beat from the selected colormap. A map beat
// keeps the input stalled through three setup steps, the restoring divider
// (one quotient bit a cycle) and the shared color multiply path (three steps
// per channel); a sample that clamps to either end of the scale skips the
// divider. The result sits in an output register, so a following scan beat is
// taken while it waits. The configuration port is always ready.
// ----------------------------------------------------------------------------
module normalized_false_color_mapper_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  nfcm_pkg::nfcm_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output nfcm_pkg::nfcm_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nfcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nfcm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import nfcm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCALE = 6'b000010,
    S_RANGE = 6'b000100,
    S_CHECK = 6'b001000,
    S_DIV   = 6'b010000,
    S_COLOR = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt;
  logic                          push_r;
  logic [CMAP_W-1:0]             cmap_r;
  logic                          sym_r;
  logic signed [SAMPLE_BITS-1:0] min_r, max_r;
  logic signed [SAMPLE_BITS-1:0] v_r;
  logic signed [EXT_W-1:0]       lo_r, hi_r, range_r, d_r;
  logic                          out_valid_r;
  nfcm_out_t                     out_data_r;

  div_req_t div_req;
  div_sts_t div_sts;
  clr_req_t clr_req;
  clr_sts_t clr_sts;

  logic                          in_acc;
  logic                          out_free;
  logic signed [SAMPLE_BITS-1:0] smp;

  assign in_stall  = (state_r != S_IDLE) || push_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign smp       = $signed(in_data.sample_value);
  assign cfg_ready = 1'b1;

  // scale bounds, optionally symmetric about zero
  logic signed [EXT_W-1:0] lo_x, hi_x, abs_lo, abs_hi, mag;
  logic signed [EXT_W-1:0] rng;

  assign lo_x   = EXT_W'(min_r);
  assign hi_x   = EXT_W'(max_r);
  assign abs_lo = (lo_x < 0) ? -lo_x : lo_x;
  assign abs_hi = (hi_x < 0) ? -hi_x : hi_x;
  assign mag    = (abs_lo > abs_hi) ? abs_lo : abs_hi;
  assign rng    = hi_r - lo_r;

  logic clamp_lo, clamp_hi;
  assign clamp_lo = (d_r <= 0);
  assign clamp_hi = (d_r >= range_r);

  always_comb begin
    div_req.start    = (state_r == S_CHECK) && !clamp_lo && !clamp_hi;
    div_req.dividend = d_r;
    div_req.divisor  = range_r;
    clr_req.cmap     = cmap_r;
    clr_req.start    = 1'b0;
    clr_req.n        = {1'b0, div_sts.quot};
    if (state_r == S_CHECK) begin
      clr_req.start = clamp_lo || clamp_hi;
      clr_req.n     = clamp_lo ? '0 : NORM_ONE;
    end else if (state_r == S_DIV) begin
      clr_req.start = div_sts.done;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.operation == OP_MAP) state_nxt = S_SCALE;
      end
      S_SCALE: state_nxt = S_RANGE;
      S_RANGE: state_nxt = S_CHECK;
      S_CHECK: state_nxt = div_req.start ? S_DIV : S_COLOR;
      S_DIV:   if (div_sts.done) state_nxt = S_COLOR;
      S_COLOR: if (clr_sts.done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      push_r      <= 1'b0;
      cmap_r      <= CM_GRAY;
      sym_r       <= 1'b0;
      min_r       <= '0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_COLORMAP:  cmap_r <= cfg_data;
          CFG_SYMMETRIC: sym_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        unique case (in_data.operation)
          OP_FIRST: begin
            min_r <= smp;
            max_r <= smp;
          end
          OP_SCAN: begin
            if (smp < min_r) min_r <= smp;
            if (smp > max_r) max_r <= smp;
          end
          default: ;
        endcase
      end
      // finished color waits here until the output register frees up
      if (state_r == S_COLOR && clr_sts.done) push_r <= 1'b1;
      else if (push_r && out_free) push_r <= 1'b0;
      if (push_r && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) v_r <= smp;
    if (state_r == S_SCALE) begin
      lo_r <= sym_r ? -mag : lo_x;
      hi_r <= sym_r ? mag : hi_x;
    end
    if (state_r == S_RANGE) begin
      range_r <= (rng == 0) ? EXT_W'(1) : rng;
      d_r     <= EXT_W'(v_r) - lo_r;
    end
    if (push_r && out_free) out_data_r <= clr_sts.rgb;
  end

  nfcm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts)
  );

  nfcm_color u_color (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (clr_req),
    .sts   (clr_sts)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/nfcm_checker.sv
// ----------------------------------------------------------------------------
// nfcm_checker
// Port-level checks of the false color mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nfcm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input nfcm_pkg::nfcm_in_t              in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input nfcm_pkg::nfcm_out_t             out_data
);
  import nfcm_pkg::*;

  logic map_acc;
  logic other_acc;

  assign map_acc   = in_valid && !in_stall && (in_data.operation == OP_MAP);
  assign other_acc = in_valid && !in_stall && (in_data.operation != OP_MAP);

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")
  `ASSERT_NEXT(a_map_busy, map_acc, in_stall, "input not stalled while a map beat is in work")
  `ASSERT_NEXT(a_scan_silent, other_acc && !out_valid, !out_valid, "scan beat produced a result")
  `ASSERT_SAME(a_rise_busy, $rose(out_valid), $past(in_stall), "result appeared without map work")

endmodule

bind normalized_false_color_mapper_core nfcm_checker u_nfcm_checker (.*);
